FILE: rtl/core/tclc_pkg.sv
// Shared constants, types and helpers for the timed color and level crossfade block.
package tclc_pkg;

	// Time and fixed-point formats.
	localparam int TIME_BITS = 32;
	localparam int FRAC_BITS = 8;
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 15;
	localparam int LEVEL_W   = 16;
	localparam int VAL_W     = BYTE_W + FRAC_BITS;
	localparam int NUM_W     = LEN_W + VAL_W;
	localparam int CNT_W     = $clog2(VAL_W);
	localparam int NCH       = 4;
	localparam int CH_W      = $clog2(NCH);

	// Reset values of the targets.
	localparam logic [BYTE_W-1:0] TGT_LEVEL_RST = 8'd0;
	localparam logic [BYTE_W-1:0] TGT_COLOR_RST = 8'd77;

	// Channel indexes.
	localparam logic [CH_W-1:0] CH_LEVEL = 2'd0;
	localparam logic [CH_W-1:0] CH_RED   = 2'd1;
	localparam logic [CH_W-1:0] CH_GREEN = 2'd2;
	localparam logic [CH_W-1:0] CH_BLUE  = 2'd3;
	localparam logic [CH_W-1:0] CH_LAST  = CH_BLUE;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_PREP,
		ST_CHAN,
		ST_MUL_A,
		ST_MUL_B,
		ST_DIV,
		ST_STORE,
		ST_COMMIT,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic            latch;
		logic            prep;
		logic            mul_a;
		logic            mul_b;
		logic            div_step;
		logic            store;
		logic            commit;
		logic            load_out;
		logic            phase;
		logic [CH_W-1:0] ch;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic active;
		logic snap;
		logic func;
	} dp_status_t;

	// Round a fixed-point value to the nearest byte, saturating at full scale.
	function automatic logic [BYTE_W-1:0] to_byte(input logic [VAL_W-1:0] v);
		logic [VAL_W:0]    sum;
		logic [BYTE_W:0]   r;
		sum = {1'b0, v} + (VAL_W+1)'(1 << (FRAC_BITS - 1));
		r   = sum[VAL_W:FRAC_BITS];
		return r[BYTE_W] ? {BYTE_W{1'b1}} : r[BYTE_W-1:0];
	endfunction

endpackage

FILE: rtl/core/tclc_ctrl.sv
// Sequencing controller for the crossfade block: handshakes, phases and channel steps.
module tclc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  tclc_pkg::dp_status_t status,
	output tclc_pkg::ctl_cmd_t   cmd
);
	import tclc_pkg::*;

	state_t            state_q, state_d;
	logic [CH_W-1:0]   ch_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic              phase_q;
	logic              out_valid_q;
	logic              out_free;
	logic              accept;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (status.snap) state_d = ST_PREP;
				else if (status.func) state_d = ST_COMMIT;
				else state_d = ST_PREP;
			end
			ST_PREP:   state_d = ST_CHAN;
			ST_CHAN:   state_d = status.active ? ST_MUL_A : ST_STORE;
			ST_MUL_A:  state_d = ST_MUL_B;
			ST_MUL_B:  state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == CNT_W'(VAL_W - 1)) state_d = ST_STORE;
			end
			ST_STORE: begin
				if (ch_q != CH_LAST) state_d = ST_CHAN;
				else if (phase_q) state_d = ST_OUT;
				else state_d = ST_COMMIT;
			end
			ST_COMMIT: state_d = ST_PREP;
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd          = '0;
		cmd.latch    = accept;
		cmd.prep     = (state_q == ST_PREP);
		cmd.mul_a    = (state_q == ST_MUL_A);
		cmd.mul_b    = (state_q == ST_MUL_B);
		cmd.div_step = (state_q == ST_DIV);
		cmd.store    = (state_q == ST_STORE);
		cmd.commit   = (state_q == ST_COMMIT);
		cmd.load_out = (state_q == ST_OUT) && out_free;
		cmd.phase    = phase_q;
		cmd.ch       = ch_q;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// State, counters and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			div_cnt_q   <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DECIDE) phase_q <= !status.snap;
			if (state_q == ST_COMMIT) phase_q <= 1'b1;
			if (state_q == ST_PREP) ch_q <= CH_LEVEL;
			else if (state_q == ST_STORE && ch_q != CH_LAST) ch_q <= ch_q + 1'b1;
			if (state_q == ST_MUL_B) div_cnt_q <= '0;
			else if (state_q == ST_DIV) div_cnt_q <= div_cnt_q + 1'b1;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/core/tclc_datapath.sv
// Datapath for the crossfade block: fade state, interpolation, divider and result registers.
module tclc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tclc_pkg::ctl_cmd_t            cmd,
	output tclc_pkg::dp_status_t          status,
	input  logic                          func,
	input  logic [tclc_pkg::TIME_BITS-1:0] now,
	input  logic [tclc_pkg::BYTE_W-1:0]   new_density,
	input  logic [tclc_pkg::BYTE_W-1:0]   new_red,
	input  logic [tclc_pkg::BYTE_W-1:0]   new_green,
	input  logic [tclc_pkg::BYTE_W-1:0]   new_blue,
	input  logic [tclc_pkg::LEN_W-1:0]    fade_duration,
	output logic [tclc_pkg::LEVEL_W-1:0]  level_now,
	output logic [tclc_pkg::BYTE_W-1:0]   red_now,
	output logic [tclc_pkg::BYTE_W-1:0]   green_now,
	output logic [tclc_pkg::BYTE_W-1:0]   blue_now,
	output logic                          fog_on
);
	import tclc_pkg::*;

	// Latched item.
	logic                 func_q;
	logic [TIME_BITS-1:0] now_q;
	logic [BYTE_W-1:0]    new_q [NCH];
	logic [LEN_W-1:0]     dur_q;

	// Fade state.
	logic [BYTE_W-1:0]    tgt_q   [NCH];
	logic [VAL_W-1:0]     start_q [NCH];
	logic [LEN_W-1:0]     len_q;
	logic [TIME_BITS-1:0] end_q;

	// Working registers.
	logic                 active_q;
	logic [LEN_W-1:0]     rem_q;
	logic [NUM_W-1:0]     prod_q;
	logic [LEN_W-1:0]     div_r_q;
	logic [VAL_W-1:0]     div_lo_q;
	logic [VAL_W-1:0]     res_q [NCH];

	// Output registers.
	logic [LEVEL_W-1:0]   level_q;
	logic [BYTE_W-1:0]    red_q, green_q, blue_q;
	logic                 fog_q;

	logic [TIME_BITS-1:0] diff;
	logic                 active_d;
	logic [LEN_W-1:0]     rem_d;
	logic [NUM_W-1:0]     num_d;
	logic [LEN_W:0]       trial;
	logic                 qbit;
	logic [LEN_W-1:0]     div_r_d;
	logic [VAL_W-1:0]     tgt_val;
	logic [VAL_W-1:0]     ch_val;
	logic [TIME_BITS:0]   end_sum;
	logic [TIME_BITS-1:0] end_d;
	logic [LEVEL_W-1:0]   level_d;

	// Remaining time of the running fade, clamped to its length.
	always_comb begin
		diff     = end_q - now_q;
		active_d = (end_q > now_q) && (len_q != '0);
		rem_d    = (diff > TIME_BITS'(len_q)) ? len_q : diff[LEN_W-1:0];
	end

	// Numerator: rem*start + (len-rem)*(target<<FRAC) + len/2.
	assign tgt_val = VAL_W'(tgt_q[cmd.ch]) << FRAC_BITS;
	assign num_d   = prod_q
		+ ((NUM_W'(len_q - rem_q) * NUM_W'(tgt_q[cmd.ch])) << FRAC_BITS)
		+ NUM_W'(len_q >> 1);

	// One restoring division step; the quotient shifts into the low word.
	always_comb begin
		trial = {div_r_q, div_lo_q[VAL_W-1]};
		qbit  = (trial >= {1'b0, len_q});
		div_r_d = qbit ? LEN_W'(trial - {1'b0, len_q}) : trial[LEN_W-1:0];
	end

	// Channel value: the target when no fade is running, else the quotient.
	assign ch_val = active_q ? div_lo_q : tgt_val;

	// Fade end time, saturating at the top of the time range.
	assign end_sum = {1'b0, now_q} + (TIME_BITS+1)'(dur_q);
	assign end_d   = end_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : end_sum[TIME_BITS-1:0];

	assign level_d = LEVEL_W'(res_q[CH_LEVEL]);

	// Item latch and working registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q          <= func;
			now_q           <= now;
			new_q[CH_LEVEL] <= new_density;
			new_q[CH_RED]   <= new_red;
			new_q[CH_GREEN] <= new_green;
			new_q[CH_BLUE]  <= new_blue;
			dur_q           <= fade_duration;
		end
		if (cmd.prep) begin
			active_q <= active_d;
			rem_q    <= rem_d;
		end
		if (cmd.mul_a) prod_q <= NUM_W'(rem_q) * NUM_W'(start_q[cmd.ch]);
		if (cmd.mul_b) begin
			div_r_q  <= num_d[NUM_W-1:VAL_W];
			div_lo_q <= num_d[VAL_W-1:0];
		end else if (cmd.div_step) begin
			div_r_q  <= div_r_d;
			div_lo_q <= {div_lo_q[VAL_W-2:0], qbit};
		end
		if (cmd.store && cmd.phase) res_q[cmd.ch] <= ch_val;
		if (cmd.load_out) begin
			level_q <= level_d;
			red_q   <= to_byte(res_q[CH_RED]);
			green_q <= to_byte(res_q[CH_GREEN]);
			blue_q  <= to_byte(res_q[CH_BLUE]);
			fog_q   <= (level_d != '0);
		end
	end

	// Fade state, set by reset: the targets to their reset values, the rest cleared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q[CH_LEVEL] <= TGT_LEVEL_RST;
			tgt_q[CH_RED]   <= TGT_COLOR_RST;
			tgt_q[CH_GREEN] <= TGT_COLOR_RST;
			tgt_q[CH_BLUE]  <= TGT_COLOR_RST;
			for (int i = 0; i < NCH; i++) start_q[i] <= '0;
			len_q <= '0;
			end_q <= '0;
		end else begin
			if (cmd.store && !cmd.phase) start_q[cmd.ch] <= ch_val;
			if (cmd.commit) begin
				for (int i = 0; i < NCH; i++) tgt_q[i] <= new_q[i];
				len_q <= dur_q;
				end_q <= end_d;
			end
		end
	end

	assign status.active = active_q;
	assign status.func   = func_q;
	assign status.snap   = func_q && (dur_q != '0);

	assign level_now = level_q;
	assign red_now   = red_q;
	assign green_now = green_q;
	assign blue_now  = blue_q;
	assign fog_on    = fog_q;

endmodule

FILE: rtl/core/timed_color_level_crossfade.sv
// Top level of the timed color and level crossfade block.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------------------
//  input   | in_valid / in_ready  | func, now, new_density, new_red, new_green,
//          |                      | new_blue, fade_duration
//  output  | out_valid / out_ready| level_now, red_now, green_now, blue_now, fog_on
//
// One item is worked on at a time; each gives one result item. The four channels go
// one after another through a shared multiply stage and a 16-step restoring divider.
// A channel skips the multiply and the divider when no fade runs; an update with a nonzero
// duration passes the channels twice, once to take the start values and once for the result.
// A finished result waits in the output register while the next item is accepted;
// the block stalls only when a new result is ready and the old one is still held.
// Reset is asynchronous: it loads the targets and clears the fade state at once.
module timed_color_level_crossfade (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           func,
	input  logic [tclc_pkg::TIME_BITS-1:0] now,
	input  logic [tclc_pkg::BYTE_W-1:0]    new_density,
	input  logic [tclc_pkg::BYTE_W-1:0]    new_red,
	input  logic [tclc_pkg::BYTE_W-1:0]    new_green,
	input  logic [tclc_pkg::BYTE_W-1:0]    new_blue,
	input  logic [tclc_pkg::LEN_W-1:0]     fade_duration,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tclc_pkg::LEVEL_W-1:0]   level_now,
	output logic [tclc_pkg::BYTE_W-1:0]    red_now,
	output logic [tclc_pkg::BYTE_W-1:0]    green_now,
	output logic [tclc_pkg::BYTE_W-1:0]    blue_now,
	output logic                           fog_on
);
	import tclc_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	// Controller.
	tclc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath.
	tclc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.func          (func),
		.now           (now),
		.new_density   (new_density),
		.new_red       (new_red),
		.new_green     (new_green),
		.new_blue      (new_blue),
		.fade_duration (fade_duration),
		.level_now     (level_now),
		.red_now       (red_now),
		.green_now     (green_now),
		.blue_now      (blue_now),
		.fog_on        (fog_on)
	);

endmodule
